FILE: hw/rtl/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg
// Types and character codes shared by the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
package dip_pkg;

  // Parser phase within one address string.
  typedef enum logic [1:0] {
    PH_START,  // expecting the first digit of a part
    PH_ZERO,   // seen a leading zero
    PH_DIGIT,  // inside the digits of a part
    PH_DROP    // discarding characters up to the next NUL
  } phase_t;

  // Radix of the current part.
  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  // Number of parts that may precede the final one.
  localparam logic [1:0] MAX_STORED = 2'd3;

endpackage

FILE: hw/rtl/dip_char_if.sv
// ----------------------------------------------------------------------------
// dip_char_if
// Valid/ready channel that carries one character of an address string.
// ----------------------------------------------------------------------------
interface dip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

FILE: hw/rtl/dip_verdict_if.sv
// ----------------------------------------------------------------------------
// dip_verdict_if
// Valid/ready channel that carries the verdict for one address string.
// ----------------------------------------------------------------------------
interface dip_verdict_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] address;

  modport source (output valid, output ok, output address, input ready);
  modport sink (input valid, input ok, input address, output ready);
endinterface

FILE: hw/rtl/dotted_ipv4_address_parser.sv
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser
// A verdict appears in the output register in the cycle after the
// terminating or offending character is accepted.
// Throughput: one character per cycle; the input stalls only while a verdict
// waits in the output register and the sink is not ready.
// Reset (synchronous, rst high) returns the parser to the start of a string
// and empties the output register.
// ----------------------------------------------------------------------------
module dotted_ipv4_address_parser
  import dip_pkg::*;
(
  input logic            clk,
  input logic            rst,
  dip_char_if.sink       chars,
  dip_verdict_if.source  verdicts
);

  // Parse state.
  phase_t      phase, phase_next;
  radix_t      radix, radix_next;
  logic [31:0] value, value_next;
  logic [1:0]  part_count, part_count_next;
  logic [31:0] stored_parts [MAX_STORED];
  logic        store_en;

  // Output register.
  logic        out_valid;
  logic        out_ok;
  logic [31:0] out_address;

  // Decode of the current character.
  logic        in_fire;
  logic        num_phase;
  logic        is_dec, is_hex_letter, is_x, is_dot, is_nul, is_space, is_end;
  radix_t      eff_radix;
  logic [3:0]  digit;
  logic [31:0] mac;
  logic        bad_char;
  logic        term;
  logic        emit;
  logic        res_ok;
  logic [31:0] res_address;
  logic [31:0] assembled;
  logic        range_ok;

  assign chars.ready = !out_valid || verdicts.ready;
  assign in_fire     = chars.valid && chars.ready;

  assign num_phase     = (phase == PH_ZERO) || (phase == PH_DIGIT);
  assign is_dec        = (chars.ch >= CH_0) && (chars.ch <= CH_9);
  assign is_hex_letter = ((chars.ch >= CH_LC_A) && (chars.ch <= CH_LC_F)) ||
                         ((chars.ch >= CH_UC_A) && (chars.ch <= CH_UC_F));
  assign is_x          = (chars.ch == CH_LC_X) || (chars.ch == CH_UC_X);
  assign is_dot        = (chars.ch == CH_DOT);
  assign is_nul        = (chars.ch == CH_NUL);
  assign is_space      = (chars.ch == CH_SPACE) ||
                         ((chars.ch >= CH_TAB) && (chars.ch <= CH_CR));
  assign is_end        = is_nul || is_space;

  // A part that began with a zero and no x prefix is octal.
  assign eff_radix = (phase == PH_ZERO) ? RADIX_OCT : radix;

  // Digit value; letters map through their low three bits.
  assign digit = is_dec ? chars.ch[3:0] : ({1'b0, chars.ch[2:0]} + 4'd9);

  // Multiply-accumulate of the part value, wrapping at 32 bits.
  always_comb begin
    unique case (eff_radix)
      RADIX_HEX: mac = {value[27:0], 4'b0} + {28'b0, digit};
      RADIX_OCT: mac = {value[28:0], 3'b0} + {28'b0, digit};
      default:   mac = {value[28:0], 3'b0} + {value[30:0], 1'b0} + {28'b0, digit};
    endcase
  end

  // Classify the character: failure, or end of a well-formed number.
  assign bad_char = ((phase == PH_START) && !is_dec) ||
                    (num_phase && !((phase == PH_ZERO) && is_x) && !is_dec &&
                     !(is_hex_letter && (eff_radix == RADIX_HEX)) &&
                     !(is_dot && (part_count != MAX_STORED)) && !is_end);
  assign term     = num_phase && is_end;
  assign emit     = in_fire && (bad_char || term);

  // Assemble the address and range-check the final part.
  always_comb begin
    unique case (part_count)
      2'd0: begin
        assembled = value;
        range_ok  = 1'b1;
      end
      2'd1: begin
        assembled = value | {stored_parts[0][7:0], 24'b0};
        range_ok  = (value[31:24] == 8'd0);
      end
      2'd2: begin
        assembled = value | {stored_parts[0][7:0], 24'b0} |
                    {stored_parts[1][15:0], 16'b0};
        range_ok  = (value[31:16] == 16'd0);
      end
      default: begin
        assembled = value | {stored_parts[0][7:0], 24'b0} |
                    {stored_parts[1][15:0], 16'b0} | {stored_parts[2][23:0], 8'b0};
        range_ok  = (value[31:8] == 24'd0);
      end
    endcase
  end

  // Result of this transaction.
  always_comb begin
    res_ok      = term && !bad_char && range_ok;
    res_address = res_ok ? assembled : 32'd0;
  end

  // Next parse state.
  always_comb begin
    phase_next      = phase;
    radix_next      = radix;
    value_next      = value;
    part_count_next = part_count;
    store_en        = 1'b0;
    if (in_fire) begin
      if (bad_char || term) begin
        // A verdict ends the string; drop the rest unless this was the NUL.
        phase_next      = is_nul ? PH_START : PH_DROP;
        radix_next      = RADIX_DEC;
        value_next      = 32'd0;
        part_count_next = 2'd0;
      end else begin
        unique case (phase)
          PH_START: begin
            value_next = {28'b0, digit};
            radix_next = RADIX_DEC;
            phase_next = (chars.ch == CH_0) ? PH_ZERO : PH_DIGIT;
          end
          PH_ZERO, PH_DIGIT: begin
            priority if ((phase == PH_ZERO) && is_x) begin
              radix_next = RADIX_HEX;
              phase_next = PH_DIGIT;
            end else if (is_dec || is_hex_letter) begin
              radix_next = eff_radix;
              value_next = mac;
              phase_next = PH_DIGIT;
            end else begin
              // Dot: store the part and start the next one.
              store_en        = 1'b1;
              part_count_next = part_count + 2'd1;
              value_next      = 32'd0;
              radix_next      = RADIX_DEC;
              phase_next      = PH_START;
            end
          end
          default: begin
            if (is_nul) begin
              phase_next = PH_START;
            end
          end
        endcase
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      radix      <= RADIX_DEC;
      value      <= 32'd0;
      part_count <= 2'd0;
    end else begin
      phase      <= phase_next;
      radix      <= radix_next;
      value      <= value_next;
      part_count <= part_count_next;
    end
  end

  // Earlier parts; only entries below part_count are ever read.
  always_ff @(posedge clk) begin
    if (store_en) begin
      stored_parts[part_count] <= value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ok      <= res_ok;
      out_address <= res_address;
    end
  end

  assign verdicts.valid   = out_valid;
  assign verdicts.ok      = out_ok;
  assign verdicts.address = out_address;

  // A failed verdict carries a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid && !verdicts.ok |-> verdicts.address == 32'd0)
    else $error("failed verdict with nonzero address");

  // A waiting verdict blocks new characters.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    verdicts.valid && !verdicts.ready |-> !chars.ready)
    else $error("input accepted while verdict stalled");

  // A NUL always returns the parser to the start of a string.
  a_nul_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_nul |=> phase == PH_START && part_count == 2'd0)
    else $error("parser not restarted after NUL");

  // While dropping, the parse is already cleared.
  a_drop_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DROP |-> value == 32'd0 && part_count == 2'd0)
    else $error("parse state not cleared while dropping");

endmodule

FILE: dv/dip_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dip_verdict_checker
// Watches the character and verdict channels of the dotted IPv4 address
// parser. Every accepted character goes through a local parser that works out
// the verdict, if any. Each accepted verdict is compared field by field with
// the oldest verdict still waiting.
// ----------------------------------------------------------------------------
module dip_verdict_checker
  import dip_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  dip_char_if    chars,
  dip_verdict_if verdicts,
  output int     fail_count,
  output int     open_count
);

  // Largest final part for two, three and four parts.
  localparam logic [31:0] LIMIT_24 = 32'h00ff_ffff;
  localparam logic [31:0] LIMIT_16 = 32'h0000_ffff;
  localparam logic [31:0] LIMIT_8  = 32'h0000_00ff;

  typedef struct {
    logic        ok;
    logic [31:0] address;
  } verdict_t;

  // Local copy of the parser state.
  phase_t      parse_phase;
  radix_t      part_radix;
  logic [31:0] part_value;
  logic [1:0]  parts_held;
  logic [31:0] held_parts [3];

  verdict_t expected_verdicts [$];

  // Return to the start of a string.
  task automatic restart_string();
    parse_phase = PH_START;
    part_value  = '0;
    part_radix  = RADIX_DEC;
    parts_held  = '0;
  endtask

  // Give a verdict; anything but NUL leaves the rest of the string to drop.
  task automatic close_string(input logic [7:0] c, input logic ok,
                              input logic [31:0] addr, output verdict_t v);
    restart_string();
    if (c != CH_NUL) begin
      parse_phase = PH_DROP;
    end
    v.ok      = ok;
    v.address = ok ? addr : '0;
  endtask

  // Character that follows the digits or the prefix of a part.
  task automatic follow_number(input logic [7:0] c, output bit emit,
                               output verdict_t v);
    logic [31:0] addr;
    logic        ok;
    logic [31:0] mul;
    emit      = 1'b0;
    v.ok      = 1'b0;
    v.address = '0;
    ok        = 1'b1;
    if (c >= CH_0 && c <= CH_9) begin
      mul = (part_radix == RADIX_HEX) ? 32'd16 : (part_radix == RADIX_OCT) ? 32'd8 : 32'd10;
      part_value  = part_value * mul + 32'(c - CH_0);
      parse_phase = PH_DIGIT;
    end else if (part_radix == RADIX_HEX &&
                 ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F))) begin
      if (c >= CH_LC_A) begin
        part_value = (part_value << 4) | 32'(c - CH_LC_A + 8'd10);
      end else begin
        part_value = (part_value << 4) | 32'(c - CH_UC_A + 8'd10);
      end
      parse_phase = PH_DIGIT;
    end else if (c == CH_DOT) begin
      if (parts_held >= MAX_STORED) begin
        close_string(c, 1'b0, '0, v);
        emit = 1'b1;
      end else begin
        held_parts[parts_held] = part_value;
        parts_held  = parts_held + 2'd1;
        parse_phase = PH_START;
        part_value  = '0;
        part_radix  = RADIX_DEC;
      end
    end else if (c != CH_NUL && c != CH_SPACE && !(c >= CH_TAB && c <= CH_CR)) begin
      close_string(c, 1'b0, '0, v);
      emit = 1'b1;
    end else begin
      // End of the address: range check the final part, merge earlier parts.
      addr = part_value;
      case (parts_held)
        2'd0: ;
        2'd1: begin
          ok   = part_value <= LIMIT_24;
          addr = addr | (held_parts[0] << 24);
        end
        2'd2: begin
          ok   = part_value <= LIMIT_16;
          addr = addr | (held_parts[0] << 24) | (held_parts[1] << 16);
        end
        default: begin
          ok   = part_value <= LIMIT_8;
          addr = addr | (held_parts[0] << 24) | (held_parts[1] << 16) | (held_parts[2] << 8);
        end
      endcase
      close_string(c, ok, addr, v);
      emit = 1'b1;
    end
  endtask

  // One accepted character through the local parser.
  task automatic parse_char(input logic [7:0] c, output bit emit, output verdict_t v);
    emit      = 1'b0;
    v.ok      = 1'b0;
    v.address = '0;
    case (parse_phase)
      PH_START: begin
        if (c < CH_0 || c > CH_9) begin
          close_string(c, 1'b0, '0, v);
          emit = 1'b1;
        end else if (c == CH_0) begin
          part_value  = '0;
          parse_phase = PH_ZERO;
        end else begin
          part_value  = 32'(c - CH_0);
          part_radix  = RADIX_DEC;
          parse_phase = PH_DIGIT;
        end
      end
      PH_ZERO: begin
        if (c == CH_LC_X || c == CH_UC_X) begin
          part_radix  = RADIX_HEX;
          parse_phase = PH_DIGIT;
        end else begin
          part_radix  = RADIX_OCT;
          parse_phase = PH_DIGIT;
          follow_number(c, emit, v);
        end
      end
      PH_DIGIT: begin
        follow_number(c, emit, v);
      end
      default: begin
        if (c == CH_NUL) begin
          restart_string();
        end
      end
    endcase
  endtask

  // Verdicts are checked before the character of the same edge is parsed,
  // since a verdict never leaves in the cycle its character arrives.
  always @(posedge clk) begin : watch
    bit       emit;
    verdict_t want;
    if (rst) begin
      restart_string();
      held_parts[0] = '0;
      held_parts[1] = '0;
      held_parts[2] = '0;
      expected_verdicts.delete();
    end else begin
      if (verdicts.valid && verdicts.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict transaction with none expected: ok %0d, address %h",
                 verdicts.ok, verdicts.address);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdicts.ok !== want.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", want.ok, verdicts.ok);
            fail_count++;
          end
          if (verdicts.address !== want.address) begin
            $error("address mismatch: expected %h, actual %h", want.address,
                   verdicts.address);
            fail_count++;
          end
        end
      end
      if (chars.valid && chars.ready) begin
        parse_char(chars.ch, emit, want);
        if (emit) begin
          expected_verdicts.push_back(want);
        end
      end
    end
    open_count = expected_verdicts.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives address strings into the dotted IPv4 address parser: a few directed
// strings first, then random addresses in all radixes with random endings,
// broken strings and byte noise. Both channels stall at random, the verdict
// side holds off once for a long stretch, and the checker beside the parser
// decides every verdict.
// ----------------------------------------------------------------------------
module tb_top
  import dip_pkg::*;
;

  logic clk;
  logic rst;
  int   fail_count;
  int   open_count;
  int   sent_count;
  bit   calm;
  bit   hold_request;
  bit   hold_done;

  dip_char_if    chars_bus ();
  dip_verdict_if verdict_bus ();

  dotted_ipv4_address_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars_bus),
    .verdicts (verdict_bus)
  );

  dip_verdict_checker parse_check (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_bus),
    .verdicts   (verdict_bus),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Verdict side: short random stalls, one long hold-off on request.
  initial begin
    verdict_bus.ready <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        verdict_bus.ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        verdict_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        verdict_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one character, with an occasional gap ahead of it.
  task automatic send_char(input logic [7:0] c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      chars_bus.valid <= 1'b0;
      chars_bus.ch    <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    chars_bus.valid <= 1'b1;
    chars_bus.ch    <= c;
    do @(posedge clk); while (!chars_bus.ready);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  // One part of an address: value near the limit or random, in a random radix.
  function automatic string make_part(input int bits);
    logic [31:0] bound;
    logic [31:0] v;
    string       s;
    byte         d;
    bound = (bits >= 32) ? 32'hffff_ffff : (32'd1 << bits) - 32'd1;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = bound;
      2: v = bound + 32'd1;
      3: v = $urandom_range(0, 255);
      4: v = $urandom;
      default: v = $urandom & bound;
    endcase
    case ($urandom_range(0, 3))
      0, 1: begin
        if ($urandom_range(0, 9) == 0) begin
          // Long enough to wrap past 32 bits.
          s = $sformatf("%0d%0d", $urandom_range(1, 9), $urandom);
        end else begin
          s = $sformatf("%0d", v);
        end
      end
      2: begin
        s = {"0", $sformatf("%0o", v)};
        if ($urandom_range(0, 2) == 0) begin
          d = CH_9 - 8'($urandom_range(0, 1));
          s[$urandom_range(1, s.len() - 1)] = d;
        end
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          s = "0x";
        end else begin
          s = "0X";
        end
        if ($urandom_range(0, 7) != 0) begin
          s = {s, $sformatf("%0h", v)};
        end
        for (int k = 2; k < s.len(); k++) begin
          if (s[k] >= CH_LC_A && s[k] <= CH_LC_F && $urandom_range(0, 1) == 1) begin
            d = s[k] - (CH_LC_A - CH_UC_A);
            s[k] = d;
          end
        end
      end
    endcase
    return s;
  endfunction

  // A dotted address of one to four parts, now and then five or with a gap.
  function automatic string make_address();
    int    n;
    string s;
    n = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        s = {s, "."};
      end
      if ($urandom_range(0, 30) == 0) begin
        continue;
      end
      if (i < n - 1) begin
        s = {s, make_part(($urandom_range(0, 4) == 0) ? 32 : 8)};
      end else begin
        s = {s, make_part((n == 1) ? 32 : (n == 2) ? 24 : (n == 3) ? 16 : 8)};
      end
    end
    return s;
  endfunction

  initial begin : stimulus
    string s;
    int    k;
    sent_count   = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    rst             <= 1'b1;
    chars_bus.valid <= 1'b0;
    chars_bus.ch    <= CH_NUL;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: empty, a high character that starts dropping, a bare
    // hex prefix, an accept at whitespace, octal with a nine, a hex letter in
    // a decimal part, and a fifth part.
    send_char(CH_NUL);
    send_char(8'hff);
    send_char(CH_NUL);
    send_text("0x");
    send_char(CH_NUL);
    send_text("0XaF");
    send_char(CH_SPACE);
    send_char(CH_NUL);
    send_text("09");
    send_char(CH_NUL);
    send_text("1e");
    send_char(CH_NUL);
    send_text("0.0.0.0.");
    send_char(CH_NUL);

    // Let every verdict of the directed part drain before going on.
    chars_bus.valid <= 1'b0;
    @(posedge clk);
    wait (open_count == 0);

    // Random strings, mostly well formed.
    while (sent_count < 730) begin
      if (sent_count > 250 && !hold_done) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (sent_count > 620) begin
        calm = 1'b1;
      end
      s = make_address();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_text(s);
          send_char(CH_NUL);
        end
        6, 7: begin
          // Accept at whitespace, then junk that is dropped.
          send_text(s);
          k = $urandom_range(8, 13);
          send_char((k == 8) ? CH_SPACE : 8'(k));
          repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(1, 255)));
          send_char(CH_NUL);
        end
        8: begin
          // One random byte dropped into the address.
          k = $urandom_range(0, s.len());
          send_text(s.substr(0, k - 1));
          send_char(8'($urandom_range(0, 255)));
          send_text(s.substr(k, s.len() - 1));
          send_char(CH_NUL);
        end
        default: begin
          repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(0, 255)));
          send_char(CH_NUL);
        end
      endcase
    end
    chars_bus.valid <= 1'b0;

    @(posedge clk);
    wait (open_count == 0);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
